// ----- sv/button_debounce_socd_hat_assert.svh -----
// Assertion macros shared by the checker.
`ifndef BUTTON_DEBOUNCE_SOCD_HAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_SOCD_HAT_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define BDSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BDSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/bdsh_pkg.sv -----
`default_nettype none

package bdsh_pkg;

  localparam int NUM_BUTTONS       = 21;
  localparam int NUM_TURBO_BUTTONS = 16;

  localparam int HAT_W    = 4;
  localparam int REPORT_W = NUM_BUTTONS + HAT_W;
  localparam int TIME_W   = 32;
  localparam int LOCK_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int RATE_W   = 2;

  // report bit positions of the four directions
  localparam int DIR_LEFT  = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_RIGHT = 2;
  localparam int DIR_UP    = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOCD_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_DEBOUNCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TACT_DEBOUNCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURBO_RATES = 2'd3;

  localparam logic [LOCK_W-1:0] DEBOUNCE_RESET = 20'd5000;

  // turbo rate codes and the ms bit that gates each
  localparam logic [RATE_W-1:0] TURBO_OFF  = 2'd0;
  localparam logic [RATE_W-1:0] TURBO_SLOW = 2'd1;
  localparam logic [RATE_W-1:0] TURBO_MID  = 2'd2;
  localparam logic [RATE_W-1:0] TURBO_FAST = 2'd3;
  localparam int MS_BIT_15HZ = 5;
  localparam int MS_BIT_30HZ = 4;
  localparam int MS_BIT_60HZ = 3;

  // hat codes
  localparam logic [HAT_W-1:0] HAT_UP         = 4'd0;
  localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd2;
  localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd4;
  localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd6;
  localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [HAT_W-1:0] HAT_NEUTRAL    = 4'hF;

  typedef struct packed {
    logic cur;   // debounced state after this scan
    logic rise;  // debounced state went 0 -> 1 on this scan
  } lane_res_t;

  function automatic logic [HAT_W-1:0] hat_code(input logic up, input logic right,
                                                input logic down, input logic left);
    logic [HAT_W-1:0] h;
    if (up && right)      h = HAT_UP_RIGHT;
    else if (down && right) h = HAT_DOWN_RIGHT;
    else if (down && left)  h = HAT_DOWN_LEFT;
    else if (up && left)    h = HAT_UP_LEFT;
    else if (up)            h = HAT_UP;
    else if (right)         h = HAT_RIGHT;
    else if (down)          h = HAT_DOWN;
    else if (left)          h = HAT_LEFT;
    else                    h = HAT_NEUTRAL;
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bdsh_lane.sv -----
`default_nettype none

module bdsh_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        raw_i,
  input  wire logic [bdsh_pkg::TIME_W-1:0] now_i,
  input  wire logic [bdsh_pkg::LOCK_W-1:0] lock_time_i,
  output bdsh_pkg::lane_res_t              res_o
);
  import bdsh_pkg::*;

  logic              state_q, state_d;
  logic [TIME_W-1:0] lock_q, lock_d;
  logic [TIME_W-1:0] diff;
  logic              expired;
  logic              flip;

  // lock has run out once (lock - now) as signed is zero or negative
  assign diff    = lock_q - now_i;
  assign expired = (diff == '0) || diff[TIME_W-1];
  assign flip    = expired && (state_q != raw_i);

  assign state_d = state_q ^ flip;
  assign lock_d  = flip ? (now_i + {{(TIME_W-LOCK_W){1'b0}}, lock_time_i}) : lock_q;

  assign res_o.cur  = state_d;
  assign res_o.rise = state_d & ~state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 1'b0;
      lock_q  <= '0;
    end else if (en_i) begin
      state_q <= state_d;
      lock_q  <= lock_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bdsh_merge.sv -----
`default_nettype none

module bdsh_merge (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          en_i,
  input  wire bdsh_pkg::lane_res_t [bdsh_pkg::NUM_BUTTONS-1:0] lane_i,
  input  wire logic                                          socd_mode_i,
  input  wire logic [bdsh_pkg::NUM_TURBO_BUTTONS*bdsh_pkg::RATE_W-1:0] turbo_rates_i,
  input  wire logic [bdsh_pkg::TIME_W-1:0]                   now_ms_i,
  output logic      [bdsh_pkg::REPORT_W-1:0]                 report_o,
  output logic      [bdsh_pkg::NUM_BUTTONS-1:0]              cleaned_o
);
  import bdsh_pkg::*;

  logic                   last_right_q, last_right_d;
  logic                   last_up_q, last_up_d;
  logic [NUM_BUTTONS-1:0] b;
  logic [NUM_BUTTONS-1:0] btn;
  logic [HAT_W-1:0]       hat;
  logic [RATE_W-1:0]      rate;
  logic                   phase;

  // direction history follows debounced rising edges; right/up win ties
  always_comb begin
    last_right_d = last_right_q;
    if (lane_i[DIR_RIGHT].rise)     last_right_d = 1'b1;
    else if (lane_i[DIR_LEFT].rise) last_right_d = 1'b0;
    last_up_d = last_up_q;
    if (lane_i[DIR_UP].rise)        last_up_d = 1'b1;
    else if (lane_i[DIR_DOWN].rise) last_up_d = 1'b0;
  end

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) b[i] = lane_i[i].cur;
    if (b[DIR_LEFT] && b[DIR_RIGHT]) begin
      if (!socd_mode_i) begin
        b[DIR_LEFT]  = 1'b0;
        b[DIR_RIGHT] = 1'b0;
      end else if (last_right_d) begin
        b[DIR_LEFT] = 1'b0;
      end else begin
        b[DIR_RIGHT] = 1'b0;
      end
    end
    if (b[DIR_UP] && b[DIR_DOWN]) begin
      if (!socd_mode_i) begin
        b[DIR_UP]   = 1'b0;
        b[DIR_DOWN] = 1'b0;
      end else if (last_up_d) begin
        b[DIR_DOWN] = 1'b0;
      end else begin
        b[DIR_UP] = 1'b0;
      end
    end
  end

  assign hat = hat_code(b[DIR_UP], b[DIR_RIGHT], b[DIR_DOWN], b[DIR_LEFT]);

  // strip directions, then turbo gating per button
  always_comb begin
    btn = b;
    btn[DIR_LEFT]  = 1'b0;
    btn[DIR_DOWN]  = 1'b0;
    btn[DIR_RIGHT] = 1'b0;
    btn[DIR_UP]    = 1'b0;
    rate  = TURBO_OFF;
    phase = 1'b0;
    for (int i = 0; i < NUM_TURBO_BUTTONS; i++) begin
      rate = turbo_rates_i[RATE_W*i +: RATE_W];
      case (rate)
        TURBO_OFF:  phase = 1'b0;
        TURBO_SLOW: phase = now_ms_i[MS_BIT_15HZ];
        TURBO_MID:  phase = now_ms_i[MS_BIT_30HZ];
        TURBO_FAST: phase = now_ms_i[MS_BIT_60HZ];
        default:    phase = 1'b0;
      endcase
      if (phase) btn[i] = 1'b0;
    end
  end

  assign report_o  = {hat, btn};
  assign cleaned_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_right_q <= 1'b0;
      last_up_q    <= 1'b0;
    end else if (en_i) begin
      last_right_q <= last_right_d;
      last_up_q    <= last_up_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/button_debounce_socd_hat.sv -----
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i/in_ready_o    raw_buttons_i, now_us_i, now_ms_i
// out      output     out_valid_o/out_ready_i  report_o, cleaned_buttons_o
// cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One scan per clock while in_ready_o is high; its result shows on the output in the cycle after the request
// is taken. This timing is set by the single output register behind the
// 21 debounce lanes and the merge stage.
// in_ready_o is low only while a result sits in the output register and the
// sink holds out_ready_i low. Reset clears all lock times, debounced bits and
// direction history, and restores the register reset values. cfg is always ready.
`default_nettype none

module button_debounce_socd_hat (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [bdsh_pkg::NUM_BUTTONS-1:0]    raw_buttons_i,
  input  wire logic [bdsh_pkg::TIME_W-1:0]         now_us_i,
  input  wire logic [bdsh_pkg::TIME_W-1:0]         now_ms_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [bdsh_pkg::REPORT_W-1:0]       report_o,
  output logic      [bdsh_pkg::NUM_BUTTONS-1:0]    cleaned_buttons_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [bdsh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bdsh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bdsh_pkg::*;

  logic                                  socd_mode_q;
  logic [LOCK_W-1:0]                     key_deb_q;
  logic [LOCK_W-1:0]                     tact_deb_q;
  logic [NUM_TURBO_BUTTONS*RATE_W-1:0]   turbo_rates_q;

  logic                         accept;
  lane_res_t [NUM_BUTTONS-1:0]  lane_res;
  logic [REPORT_W-1:0]          report_d;
  logic [NUM_BUTTONS-1:0]       cleaned_d;
  logic                         out_valid_q;
  logic [REPORT_W-1:0]          report_q;
  logic [NUM_BUTTONS-1:0]       cleaned_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      socd_mode_q   <= 1'b1;
      key_deb_q     <= DEBOUNCE_RESET;
      tact_deb_q    <= DEBOUNCE_RESET;
      turbo_rates_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SOCD_MODE:     socd_mode_q   <= cfg_data_i[0];
        CFG_KEY_DEBOUNCE:  key_deb_q     <= cfg_data_i[LOCK_W-1:0];
        CFG_TACT_DEBOUNCE: tact_deb_q    <= cfg_data_i[LOCK_W-1:0];
        CFG_TURBO_RATES:   turbo_rates_q <= cfg_data_i[NUM_TURBO_BUTTONS*RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bdsh_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (accept),
      .raw_i       (raw_buttons_i[g]),
      .now_i       (now_us_i),
      .lock_time_i ((g < NUM_TURBO_BUTTONS) ? key_deb_q : tact_deb_q),
      .res_o       (lane_res[g])
    );
  end

  bdsh_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (accept),
    .lane_i        (lane_res),
    .socd_mode_i   (socd_mode_q),
    .turbo_rates_i (turbo_rates_q),
    .now_ms_i      (now_ms_i),
    .report_o      (report_d),
    .cleaned_o     (cleaned_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      report_q  <= report_d;
      cleaned_q <= cleaned_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign report_o          = report_q;
  assign cleaned_buttons_o = cleaned_q;

endmodule

`default_nettype wire

// ----- sv/bdsh_checker.sv -----
`default_nettype none
`include "button_debounce_socd_hat_assert.svh"

module bdsh_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic [bdsh_pkg::REPORT_W-1:0]       report_o,
  input wire logic [bdsh_pkg::NUM_BUTTONS-1:0]    cleaned_buttons_o
);
  import bdsh_pkg::*;

  // a held result keeps its payload
  `BDSH_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(report_o) && $stable(cleaned_buttons_o), "result dropped or changed while stalled")

  // every taken request shows a result in the next cycle
  `BDSH_ASSERT(a_in_to_out, in_valid_i && in_ready_o |=> out_valid_o, "taken request gave no result")

  // hat field is one of the nine defined codes
  `BDSH_ASSERT(a_hat_legal, out_valid_o |-> !report_o[REPORT_W-1] || report_o[REPORT_W-1:NUM_BUTTONS] == HAT_NEUTRAL, "illegal hat code")

  // no opposing directions survive cleaning
  `BDSH_ASSERT(a_no_socd, out_valid_o |-> !(cleaned_buttons_o[DIR_LEFT] && cleaned_buttons_o[DIR_RIGHT]) && !(cleaned_buttons_o[DIR_UP] && cleaned_buttons_o[DIR_DOWN]), "opposing directions both set")

  // buttons past the turbo range pass straight into the report
  `BDSH_ASSERT(a_tact_pass, out_valid_o |-> report_o[NUM_BUTTONS-1:NUM_TURBO_BUTTONS] == cleaned_buttons_o[NUM_BUTTONS-1:NUM_TURBO_BUTTONS], "report and cleaned bits disagree")

endmodule

bind button_debounce_socd_hat bdsh_checker u_bdsh_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .report_o          (report_o),
  .cleaned_buttons_o (cleaned_buttons_o)
);

`default_nettype wire

// ----- tb/sv/button_debounce_socd_hat_checker.sv -----
`default_nettype none

module button_debounce_socd_hat_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_i,
  input  wire logic [bdsh_pkg::NUM_BUTTONS-1:0]    raw_buttons_i,
  input  wire logic [bdsh_pkg::TIME_W-1:0]         now_us_i,
  input  wire logic [bdsh_pkg::TIME_W-1:0]         now_ms_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_ready_i,
  input  wire logic [bdsh_pkg::REPORT_W-1:0]       report_i,
  input  wire logic [bdsh_pkg::NUM_BUTTONS-1:0]    cleaned_buttons_i,
  input  wire logic                                cfg_valid_i,
  input  wire logic                                cfg_ready_i,
  input  wire logic [bdsh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bdsh_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int unsigned                              mismatches_o,
  output int unsigned                              pending_o
);
  import bdsh_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [NUM_BUTTONS-1:0] DPAD_MASK =
    NUM_BUTTONS'((1 << DIR_LEFT) | (1 << DIR_DOWN) | (1 << DIR_RIGHT) | (1 << DIR_UP));

  typedef struct packed {
    logic [REPORT_W-1:0]    report;
    logic [NUM_BUTTONS-1:0] cleaned;
  } scan_out_t;

  // register copies
  logic                   socd_last_wins;
  logic [LOCK_W-1:0]      key_lock_us;
  logic [LOCK_W-1:0]      tact_lock_us;
  logic [CFG_DATA_W-1:0]  turbo_sel;

  // per-button debounce state and direction history
  logic [NUM_BUTTONS-1:0] stable_q;
  logic [TIME_W-1:0]      lock_end [NUM_BUTTONS];
  logic                   last_right;
  logic                   last_up;

  scan_out_t              expected_scans_q [$];
  scan_out_t              want;
  int unsigned            mismatch_cnt;

  function automatic logic [HAT_W-1:0] dpad_to_hat(input logic [NUM_BUTTONS-1:0] b);
    logic [HAT_W-1:0] hat;
    // first match wins: diagonals before single directions
    casez ({b[DIR_UP], b[DIR_RIGHT], b[DIR_DOWN], b[DIR_LEFT]})
      4'b11??: hat = HAT_UP_RIGHT;
      4'b?11?: hat = HAT_DOWN_RIGHT;
      4'b??11: hat = HAT_DOWN_LEFT;
      4'b1??1: hat = HAT_UP_LEFT;
      4'b1???: hat = HAT_UP;
      4'b?1??: hat = HAT_RIGHT;
      4'b??1?: hat = HAT_DOWN;
      4'b???1: hat = HAT_LEFT;
      default: hat = HAT_NEUTRAL;
    endcase
    return hat;
  endfunction

  function automatic scan_out_t predict_scan(input logic [NUM_BUTTONS-1:0] raw,
                                             input logic [TIME_W-1:0] us,
                                             input logic [TIME_W-1:0] ms);
    logic [NUM_BUTTONS-1:0] prev;
    logic [NUM_BUTTONS-1:0] now_b;
    logic [NUM_BUTTONS-1:0] rose;
    logic [NUM_BUTTONS-1:0] b;
    logic [TIME_W-1:0]      left_us;
    logic [LOCK_W-1:0]      span;
    logic [REPORT_W-1:0]    rep;
    logic [RATE_W-1:0]      rate;
    logic                   gate;
    scan_out_t              res;
    prev  = stable_q;
    now_b = prev;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      // lock is over once the wrapped remaining time is zero or negative
      left_us = lock_end[i] - us;
      span = (i < NUM_TURBO_BUTTONS) ? key_lock_us : tact_lock_us;
      if ((left_us == '0 || left_us[TIME_W-1]) && now_b[i] != raw[i]) begin
        now_b[i]    = raw[i];
        lock_end[i] = us + TIME_W'(span);
      end
    end
    stable_q = now_b;

    rose = now_b & ~prev;
    if (rose[DIR_RIGHT])     last_right = 1'b1;
    else if (rose[DIR_LEFT]) last_right = 1'b0;
    if (rose[DIR_UP])        last_up = 1'b1;
    else if (rose[DIR_DOWN]) last_up = 1'b0;

    b = now_b;
    if (b[DIR_LEFT] && b[DIR_RIGHT]) begin
      if (!socd_last_wins) begin
        b[DIR_LEFT]  = 1'b0;
        b[DIR_RIGHT] = 1'b0;
      end else if (last_right) begin
        b[DIR_LEFT] = 1'b0;
      end else begin
        b[DIR_RIGHT] = 1'b0;
      end
    end
    if (b[DIR_UP] && b[DIR_DOWN]) begin
      if (!socd_last_wins) begin
        b[DIR_UP]   = 1'b0;
        b[DIR_DOWN] = 1'b0;
      end else if (last_up) begin
        b[DIR_DOWN] = 1'b0;
      end else begin
        b[DIR_UP] = 1'b0;
      end
    end

    rep = {dpad_to_hat(b), b & ~DPAD_MASK};
    for (int i = 0; i < NUM_TURBO_BUTTONS; i++) begin
      rate = turbo_sel[2*i +: RATE_W];
      case (rate)
        TURBO_SLOW: gate = ms[MS_BIT_15HZ];
        TURBO_MID:  gate = ms[MS_BIT_30HZ];
        TURBO_FAST: gate = ms[MS_BIT_60HZ];
        default:    gate = 1'b0;
      endcase
      if (gate) rep[i] = 1'b0;
    end

    res.report  = rep;
    res.cleaned = b;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      socd_last_wins = 1'b1;
      key_lock_us    = DEBOUNCE_RESET;
      tact_lock_us   = DEBOUNCE_RESET;
      turbo_sel      = '0;
      stable_q       = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) lock_end[i] = '0;
      last_right     = 1'b0;
      last_up        = 1'b0;
      expected_scans_q.delete();
      mismatch_cnt   = 0;
      mismatches_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SOCD_MODE:     socd_last_wins = cfg_data_i[0];
          CFG_KEY_DEBOUNCE:  key_lock_us    = cfg_data_i[LOCK_W-1:0];
          CFG_TACT_DEBOUNCE: tact_lock_us   = cfg_data_i[LOCK_W-1:0];
          CFG_TURBO_RATES:   turbo_sel      = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_scans_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("checker: result without request: report %h cleaned %h",
                     report_i, cleaned_buttons_i);
        end else begin
          want = expected_scans_q.pop_front();
          if (report_i !== want.report || cleaned_buttons_i !== want.cleaned) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
              $display("checker: mismatch report exp %h got %h, cleaned exp %h got %h",
                       want.report, report_i, want.cleaned, cleaned_buttons_i);
          end
        end
      end

      if (in_valid_i && in_ready_i)
        expected_scans_q.push_back(predict_scan(raw_buttons_i, now_us_i, now_ms_i));

      pending_o    <= expected_scans_q.size();
      mismatches_o <= mismatch_cnt;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
  import bdsh_pkg::*;

  localparam int          NUM_PHASES  = 11;
  localparam int          PHASE_ITEMS = 150;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [NUM_BUTTONS-1:0] ALL_BUTTONS = '1;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_ready;
  logic [NUM_BUTTONS-1:0] raw_buttons;
  logic [TIME_W-1:0]      now_us;
  logic [TIME_W-1:0]      now_ms;
  logic                   out_valid;
  logic                   out_ready;
  logic [REPORT_W-1:0]    report;
  logic [NUM_BUTTONS-1:0] cleaned_buttons;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned            mismatches;
  int unsigned            pending;
  int unsigned            cycle_cnt;

  bit                     calm;
  int                     in_idle_odds;
  int                     out_idle_odds;
  int                     stall_left;
  logic [NUM_BUTTONS-1:0] held_raw;
  logic [TIME_W-1:0]      us_t;
  logic [TIME_W-1:0]      ms_t;

  button_debounce_socd_hat i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .raw_buttons_i     (raw_buttons),
    .now_us_i          (now_us),
    .now_ms_i          (now_ms),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .report_o          (report),
    .cleaned_buttons_o (cleaned_buttons),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  button_debounce_socd_hat_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .raw_buttons_i     (raw_buttons),
    .now_us_i          (now_us),
    .now_ms_i          (now_ms),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .report_i          (report),
    .cleaned_buttons_i (cleaned_buttons),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sink side: random stall bursts
  always @(posedge clk_i) begin
    if (calm || out_idle_odds == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, out_idle_odds) == 0) begin
      stall_left <= $urandom_range(1, 6) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_scan(input logic [NUM_BUTTONS-1:0] raw,
                           input logic [TIME_W-1:0] us,
                           input logic [TIME_W-1:0] ms);
    int gap;
    gap = 0;
    if (!calm && in_idle_odds != 0 && $urandom_range(0, in_idle_odds) == 0)
      gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    raw_buttons <= raw;
    now_us      <= us;
    now_ms      <= ms;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // hold off the sender until every outstanding request has its result
  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // unused upper data bits carry noise, the block must mask them
  task automatic program_regs(input logic socd, input logic [LOCK_W-1:0] key,
                              input logic [LOCK_W-1:0] tact, input logic [CFG_DATA_W-1:0] turbo);
    write_reg(CFG_SOCD_MODE, ($urandom() & ~32'h1) | CFG_DATA_W'(socd));
    write_reg(CFG_KEY_DEBOUNCE, ($urandom() & 32'hFFF0_0000) | CFG_DATA_W'(key));
    write_reg(CFG_TACT_DEBOUNCE, ($urandom() & 32'hFFF0_0000) | CFG_DATA_W'(tact));
    write_reg(CFG_TURBO_RATES, turbo);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LOCK_W-1:0] pick_lock();
    logic [LOCK_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = LOCK_W'($urandom_range(1, 64));
      2:       v = LOCK_W'($urandom_range(100, 20000));
      3:       v = '1;
      default: v = LOCK_W'($urandom_range(0, 1000000));
    endcase
    return v;
  endfunction

  task automatic random_scan(input logic [LOCK_W-1:0] span);
    logic [NUM_BUTTONS-1:0] flip;
    int pick;
    pick = $urandom_range(0, 19);
    flip = '0;
    if (pick < 12) begin
      // mostly a few buttons change, directions favored to stress cleaning
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 7))
          0:       flip[DIR_LEFT]  = 1'b1;
          1:       flip[DIR_DOWN]  = 1'b1;
          2:       flip[DIR_RIGHT] = 1'b1;
          3:       flip[DIR_UP]    = 1'b1;
          default: flip[$urandom_range(0, NUM_BUTTONS-1)] = 1'b1;
        endcase
      end
      held_raw = held_raw ^ flip;
    end else if (pick < 15) begin
      held_raw = NUM_BUTTONS'($urandom());
    end else if (pick == 15) begin
      held_raw = '0;
    end else if (pick == 16) begin
      held_raw = ALL_BUTTONS;
    end

    pick = $urandom_range(0, 15);
    if (pick == 0)      us_t = $urandom();
    else if (pick == 1) us_t = us_t + TIME_W'(span);
    else                us_t = us_t + TIME_W'($urandom_range(0, int'(span) / 2 + 2));
    if ($urandom_range(0, 31) == 0) ms_t = $urandom();
    else                            ms_t = ms_t + TIME_W'($urandom_range(0, 12));
    send_scan(held_raw, us_t, ms_t);
  endtask

  initial begin
    logic              socd_v;
    logic [LOCK_W-1:0] key_v;
    logic [LOCK_W-1:0] tact_v;
    logic [LOCK_W-1:0] span_v;
    logic [CFG_DATA_W-1:0] turbo_v;

    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    raw_buttons   = '0;
    now_us        = '0;
    now_ms        = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SOCD_MODE;
    cfg_data      = '0;
    cycle_cnt     = 0;
    calm          = 1'b0;
    in_idle_odds  = 4;
    out_idle_odds = 4;
    stall_left    = 0;
    held_raw      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: last-wins, 5000 us locks, no turbo
    send_scan('0, 32'h0, 32'h0);
    send_scan(ALL_BUTTONS, 32'h0, 32'hFFFF_FFFF);       // same-scan presses
    send_scan('0, 32'd4999, 32'h0);                     // still locked
    send_scan('0, 32'd5000, 32'h0);                     // lock ends exactly
    send_scan(NUM_BUTTONS'(1 << DIR_LEFT), 32'd10000, 32'h0);
    send_scan(NUM_BUTTONS'((1 << DIR_LEFT) | (1 << DIR_RIGHT)), 32'd15000, 32'h0);
    send_scan(NUM_BUTTONS'((1 << DIR_UP) | (1 << DIR_DOWN)), 32'd20000, 32'h0);
    send_scan(NUM_BUTTONS'(1 << DIR_DOWN), 32'd26000, 32'h0);
    send_scan(NUM_BUTTONS'((1 << DIR_UP) | (1 << DIR_DOWN)), 32'd32000, 32'h0);
    // lock end wraps past 2^32
    send_scan(ALL_BUTTONS, 32'hFFFF_F000, 32'h0);
    send_scan('0, 32'h0000_0100, 32'h0);
    send_scan('0, 32'h0000_0388, 32'h0);
    // remaining time at the edges of the signed range
    send_scan(ALL_BUTTONS, 32'h8000_1710, 32'hFFFF_FFFF);
    send_scan('0, 32'h0000_2A99, 32'h0);
    send_scan('0, 32'h8000_2A97, 32'h0);
    send_scan('0, 32'h8000_2A98, 32'hFFFF_FFFF);

    wait_drained;
    program_regs(1'b0, '0, '0, 32'hFFFF_FFFF);
    send_scan(ALL_BUTTONS, 32'h0001_0000, 32'h0);       // neutral cancel, turbo phase low
    send_scan(ALL_BUTTONS, 32'h0001_0001, 32'h8);       // 60 Hz gate
    send_scan(NUM_BUTTONS'((1 << DIR_LEFT) | (1 << DIR_UP)), 32'h0001_0002, 32'h30);
    send_scan(NUM_BUTTONS'((1 << DIR_RIGHT) | (1 << DIR_DOWN)), 32'h0001_0003, 32'h10);
    send_scan('0, 32'h0001_0004, 32'h37);

    us_t     = 32'h0001_0004;
    ms_t     = 32'h37;
    held_raw = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin socd_v = 1'b0; key_v = '0;      tact_v = '1;     turbo_v = 32'h5555_5555; end
        1: begin socd_v = 1'b1; key_v = '1;      tact_v = '0;     turbo_v = 32'hAAAA_AAAA; end
        2: begin socd_v = 1'b1; key_v = 20'd5000; tact_v = 20'd1; turbo_v = '0;           end
        3: begin socd_v = 1'b0; key_v = 20'd1;   tact_v = 20'd64; turbo_v = 32'hFFFF_FFFF; end
        default: begin
          socd_v  = 1'($urandom_range(0, 1));
          key_v   = pick_lock();
          tact_v  = pick_lock();
          turbo_v = $urandom();
        end
      endcase
      span_v = (key_v > tact_v) ? key_v : tact_v;
      in_idle_odds  = (p % 3 == 2) ? 0 : $urandom_range(2, 8);
      out_idle_odds = (p % 4 == 1) ? 0 : $urandom_range(2, 8);
      wait_drained;
      calm = (p >= NUM_PHASES - 2);
      program_regs(socd_v, key_v, tact_v, turbo_v);
      for (int n = 0; n < PHASE_ITEMS; n++) random_scan(span_v);
    end

    wait_drained;
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/bdsh_pkg.sv
sv/bdsh_lane.sv
sv/bdsh_merge.sv
sv/button_debounce_socd_hat.sv
sv/bdsh_checker.sv
tb/sv/button_debounce_socd_hat_checker.sv
tb/sv/testbench.sv
